// ===== rtl/ftc_pkg.sv =====
// ----------------------------------------------------------------------------
// ftc_pkg: shared types and constants of the fridge thermostat controller
// Holds the input and result word layouts, command codes, register indexes
// and the reset values of the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

package ftc_pkg;

  // One input word: a tick or a door switch change event.
  typedef struct packed {
    logic              command;
    logic              door_open;
    logic signed [11:0] sensed_temp;
    logic [5:0]        dial;
  } ftc_in_t;

  // One result word: the drive levels after the item.
  typedef struct packed {
    logic fan_on;
    logic motor_on;
    logic heater_on;
    logic light_on;
    logic buzzer_on;
  } ftc_out_t;

  // Command codes.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_DOOR = 1'b1;

  // Register indexes (word address bits [4:2]).
  localparam logic [2:0] REG_TARGET_MIN  = 3'd0;
  localparam logic [2:0] REG_TARGET_MAX  = 3'd1;
  localparam logic [2:0] REG_HYST_BAND   = 3'd2;
  localparam logic [2:0] REG_HEATER_LIM  = 3'd3;
  localparam logic [2:0] REG_MOTOR_HOLD  = 3'd4;
  localparam logic [2:0] REG_DOOR_ALARM  = 3'd5;

  // Register reset values.
  localparam logic signed [11:0] TARGET_MIN_RST = 12'sd64;
  localparam logic signed [11:0] TARGET_MAX_RST = 12'sd160;
  localparam logic [7:0]         HYST_BAND_RST  = 8'd16;
  localparam logic [15:0]        HEATER_LIM_RST = 16'd80;
  localparam logic [15:0]        MOTOR_HOLD_RST = 16'd360;
  localparam logic [15:0]        DOOR_ALARM_RST = 16'd120;

  // Door counter wrap on a closed-door tick.
  localparam logic [15:0] DOOR_WRAP_FROM = 16'd65530;
  localparam logic [15:0] DOOR_WRAP_TO   = 16'd7;

  // Width of the exact target arithmetic (scaled by the dial step count).
  localparam int TGT_W = 24;

endpackage

`default_nettype wire

// ===== rtl/fridge_thermostat_controller_unit.sv =====
// ----------------------------------------------------------------------------
// fridge_thermostat_controller_unit: refrigerator thermostat controller
// Runs the door alarm, hysteresis cooling control with minimum hold time,
// the heater pulse and the fan reaction to door events.
// ----------------------------------------------------------------------------
// The block takes one input word per clock cycle while the result side drains,
// and returns one result word for each, in order. A word is accepted into an
// input register; when the result register is empty or being drained, the
// control logic (one small multiply by the dial and a few compares) updates
// the controller state and loads the result register. A stalled result
// register holds the input side back only once the input register is also
// full. Configuration writes take effect for the next word processed.
`default_nettype none

module fridge_thermostat_controller_unit #(
  parameter int DIAL_STEPS = 40
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ftc_pkg::ftc_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ftc_pkg::ftc_out_t out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  import ftc_pkg::*;

  localparam logic [7:0] DIAL_OFF = 8'(DIAL_STEPS);

  // Configuration registers.
  logic signed [11:0] target_min;
  logic signed [11:0] target_max;
  logic [7:0]         hysteresis_band;
  logic [15:0]        heater_limit;
  logic [15:0]        motor_hold;
  logic [15:0]        door_alarm_ticks;

  // Input register.
  logic    s1_valid;
  ftc_in_t s1_item;
  logic    advance;

  // Controller state.
  logic [15:0] door_ticks, door_ticks_next;
  logic        alarm_reg, alarm_reg_next;
  logic        cooling_active, cooling_active_next;
  logic [15:0] change_age, change_age_next;
  logic        heat_active, heat_active_next;
  logic [15:0] heat_ticks, heat_ticks_next;
  logic        fan_reg, fan_reg_next;
  logic        motor_reg, motor_reg_next;
  logic        heater_reg, heater_reg_next;

  // Target arithmetic, all scaled by the dial step count.
  logic signed [TGT_W-1:0] steps_w;
  logic signed [TGT_W-1:0] lo_w;
  logic signed [TGT_W-1:0] span_w;
  logic signed [TGT_W-1:0] dial_w;
  logic signed [TGT_W-1:0] temp_w;
  logic signed [TGT_W-1:0] num;
  logic signed [TGT_W-1:0] temp_d;
  logic signed [TGT_W-1:0] hd;
  logic                    too_warm;
  logic                    too_cold;
  logic                    at_target;
  logic                    hold_running;

  assign pready = 1'b1;

  // Configuration writes and reads.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_min       <= TARGET_MIN_RST;
      target_max       <= TARGET_MAX_RST;
      hysteresis_band  <= HYST_BAND_RST;
      heater_limit     <= HEATER_LIM_RST;
      motor_hold       <= MOTOR_HOLD_RST;
      door_alarm_ticks <= DOOR_ALARM_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_TARGET_MIN: target_min       <= signed'(pwdata[11:0]);
        REG_TARGET_MAX: target_max       <= signed'(pwdata[11:0]);
        REG_HYST_BAND:  hysteresis_band  <= pwdata[7:0];
        REG_HEATER_LIM: heater_limit     <= pwdata[15:0];
        REG_MOTOR_HOLD: motor_hold       <= pwdata[15:0];
        REG_DOOR_ALARM: door_alarm_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_TARGET_MIN: prdata = {20'd0, target_min};
      REG_TARGET_MAX: prdata = {20'd0, target_max};
      REG_HYST_BAND:  prdata = {24'd0, hysteresis_band};
      REG_HEATER_LIM: prdata = {16'd0, heater_limit};
      REG_MOTOR_HOLD: prdata = {16'd0, motor_hold};
      REG_DOOR_ALARM: prdata = {16'd0, door_alarm_ticks};
      default:        prdata = 32'd0;
    endcase
  end

  // Flow control: the input register moves into the result register
  // whenever that one is empty or being drained.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_item <= in_data;
    end
  end

  // Exact target compares by cross multiplication.
  always_comb begin
    steps_w  = TGT_W'(DIAL_STEPS);
    lo_w     = TGT_W'(target_min);
    span_w   = TGT_W'(target_max) - lo_w;
    dial_w   = TGT_W'($signed({1'b0, s1_item.dial}));
    temp_w   = TGT_W'(s1_item.sensed_temp);
    num      = lo_w * steps_w + span_w * dial_w;
    temp_d   = temp_w * steps_w;
    hd       = TGT_W'($signed({1'b0, hysteresis_band})) * steps_w;
    too_warm = (temp_d <<< 1) > ((num <<< 1) + hd);
    too_cold = (temp_d <<< 1) < ((num <<< 1) - hd);
    at_target = temp_d >= num;
    hold_running = (change_age != 16'd0) &&
                   ({1'b0, change_age} < ({1'b0, motor_hold} + 17'd1));
  end

  // Next controller state for the word in the input register.
  always_comb begin
    door_ticks_next     = door_ticks;
    alarm_reg_next      = alarm_reg;
    cooling_active_next = cooling_active;
    change_age_next     = change_age;
    heat_active_next    = heat_active;
    heat_ticks_next     = heat_ticks;
    fan_reg_next        = fan_reg;
    motor_reg_next      = motor_reg;
    heater_reg_next     = heater_reg;

    if (s1_item.command == CMD_DOOR) begin
      // Door event: fan stops on opening, restarts on closing if the motor runs.
      if (s1_item.door_open) begin
        fan_reg_next = 1'b0;
      end else if (motor_reg) begin
        fan_reg_next = 1'b1;
      end
      door_ticks_next = 16'd0;
    end else begin
      // Door-open counter and buzzer.
      if (s1_item.door_open) begin
        if (door_ticks < door_alarm_ticks) begin
          door_ticks_next = door_ticks + 16'd1;
        end else begin
          alarm_reg_next = 1'b1;
        end
      end else begin
        alarm_reg_next = 1'b0;
        if (door_ticks == DOOR_WRAP_FROM) begin
          door_ticks_next = DOOR_WRAP_TO;
        end else begin
          door_ticks_next = door_ticks + 16'd1;
        end
      end

      if ({2'b00, s1_item.dial} == DIAL_OFF) begin
        // Dial at off: fan, motor and heater stop, cooling mode is kept.
        fan_reg_next     = 1'b0;
        motor_reg_next   = 1'b0;
        heater_reg_next  = 1'b0;
        heat_active_next = 1'b0;
        change_age_next  = 16'd0;
      end else begin
        // Hysteresis switching with minimum hold time.
        if (hold_running) begin
          change_age_next = change_age + 16'd1;
        end else if (!s1_item.door_open && too_warm && !cooling_active) begin
          cooling_active_next = 1'b1;
          change_age_next     = 16'd1;
        end else if (too_cold && cooling_active) begin
          cooling_active_next = 1'b0;
          change_age_next     = 16'd1;
        end

        if (cooling_active_next) begin
          if (!s1_item.door_open) begin
            fan_reg_next = 1'b1;
          end
          motor_reg_next   = 1'b1;
          heater_reg_next  = 1'b0;
          heat_active_next = 1'b0;
        end else begin
          fan_reg_next   = 1'b0;
          motor_reg_next = 1'b0;
          // Heater pulse, cut short once at target past half its length.
          if (at_target && (heat_ticks > (heater_limit >> 1))) begin
            heater_reg_next  = 1'b0;
            heat_active_next = 1'b0;
          end else begin
            heat_active_next = 1'b1;
            if (heat_active) begin
              if (heat_ticks > heater_limit) begin
                heater_reg_next = 1'b0;
              end else begin
                heat_ticks_next = heat_ticks + 16'd1;
              end
            end else begin
              // A fresh pulse starts at zero, which never exceeds the limit.
              heater_reg_next = 1'b1;
              heat_ticks_next = 16'd1;
            end
          end
        end
      end
    end
  end

  // State and result registers; the light follows the latched door level.
  always_ff @(posedge clk) begin
    if (rst) begin
      door_ticks     <= 16'd0;
      alarm_reg      <= 1'b0;
      cooling_active <= 1'b0;
      change_age     <= 16'd0;
      heat_active    <= 1'b0;
      heat_ticks     <= 16'd0;
      fan_reg        <= 1'b0;
      motor_reg      <= 1'b0;
      heater_reg     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (advance) begin
        door_ticks     <= door_ticks_next;
        alarm_reg      <= alarm_reg_next;
        cooling_active <= cooling_active_next;
        change_age     <= change_age_next;
        heat_active    <= heat_active_next;
        heat_ticks     <= heat_ticks_next;
        fan_reg        <= fan_reg_next;
        motor_reg      <= motor_reg_next;
        heater_reg     <= heater_reg_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_data.fan_on    <= fan_reg_next;
      out_data.motor_on  <= motor_reg_next;
      out_data.heater_on <= heater_reg_next;
      out_data.light_on  <= s1_item.door_open;
      out_data.buzzer_on <= alarm_reg_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ftc_checker.sv =====
// ----------------------------------------------------------------------------
// ftc_checker: port-level checks of the fridge thermostat controller
// Watches the result channel and is bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module ftc_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire ftc_pkg::ftc_out_t out_data
);

  // A result waiting for the sink keeps its word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Compressor and heater never drive together.
  a_motor_heater: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.motor_on && out_data.heater_on))
    else $error("motor and heater both on");

  // The fan only runs with the compressor.
  a_fan_motor: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.fan_on |-> out_data.motor_on)
    else $error("fan on without motor");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending after reset");

endmodule

bind fridge_thermostat_controller_unit ftc_checker u_ftc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: fridge thermostat controller, self-checking bench
// Drives ticks and door events through the valid/ready input channel and
// checks every result word against a cycle-free prediction of the door
// alarm, the hysteresis cooling with hold time, the heater pulse and the
// fan. Settings are changed over the APB port between phases while idle.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ftc_pkg::*;

  localparam int STEPS = 40;
  localparam logic [5:0] DIAL_OFF = 6'(STEPS);
  localparam bit [15:0] DOOR_COUNT_TOP = 16'd65530;
  localparam bit [15:0] DOOR_COUNT_RESTART = 16'd7;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PRESSURE_CYCLES = 64;
  localparam int CLOSED_RUN_TICKS = 40;
  localparam int PHASE_WORDS = 230;

  // Expected drive levels, worked out from each accepted input word.
  class thermostat_tracker;
    bit signed [11:0] tgt_lo, tgt_hi;
    bit [7:0] band;
    bit [15:0] heat_limit, hold_ticks, alarm_limit;
    bit door_lvl, buzzer, cooling, heat_active, fan, motor, heater;
    bit [15:0] door_ticks, change_age, heat_ticks;
    ftc_out_t expected_drive[$];
    int mismatches;

    function new();
      tgt_lo = 12'sd64;
      tgt_hi = 12'sd160;
      band = 8'd16;
      heat_limit = 16'd80;
      hold_ticks = 16'd360;
      alarm_limit = 16'd120;
    endfunction

    function void set_register(logic [2:0] index, logic [31:0] value);
      case (index)
        REG_TARGET_MIN: tgt_lo = value[11:0];
        REG_TARGET_MAX: tgt_hi = value[11:0];
        REG_HYST_BAND: band = value[7:0];
        REG_HEATER_LIM: heat_limit = value[15:0];
        REG_MOTOR_HOLD: hold_ticks = value[15:0];
        REG_DOOR_ALARM: alarm_limit = value[15:0];
        default: ;
      endcase
    endfunction

    // Heater pulse while cooling rests; it stops early once at target.
    function void run_heater(bit enable, bit at_target);
      if (enable && at_target && heat_ticks > (heat_limit >> 1))
        enable = 1'b0;
      if (enable && !heat_active) begin
        heat_ticks = '0;
        heater = 1'b1;
        heat_active = 1'b1;
      end
      if (enable && heat_active) begin
        if (heat_ticks > heat_limit)
          heater = 1'b0;
        else
          heat_ticks = heat_ticks + 16'd1;
      end
      if (!enable) begin
        heater = 1'b0;
        heat_active = 1'b0;
      end
    endfunction

    function void take_word(ftc_in_t w);
      longint steps, lo, hi, num, hd, t, t2;
      ftc_out_t drive;
      door_lvl = w.door_open;
      if (w.command == CMD_DOOR) begin
        // A door event only moves the fan and clears the open counter.
        if (w.door_open)
          fan = 1'b0;
        else if (motor)
          fan = 1'b1;
        door_ticks = '0;
      end else begin
        // Door-open counter and buzzer.
        if (w.door_open) begin
          if (door_ticks < alarm_limit)
            door_ticks = door_ticks + 16'd1;
          else
            buzzer = 1'b1;
        end else begin
          buzzer = 1'b0;
          if (door_ticks == DOOR_COUNT_TOP)
            door_ticks = DOOR_COUNT_RESTART;
          else
            door_ticks = door_ticks + 16'd1;
        end

        if (w.dial == DIAL_OFF) begin
          fan = 1'b0;
          motor = 1'b0;
          run_heater(1'b0, 1'b0);
          change_age = '0;
        end else begin
          // Target kept as a fraction over the dial step count, compared exactly.
          steps = STEPS;
          lo = tgt_lo;
          hi = tgt_hi;
          t = $signed(w.sensed_temp);
          num = lo * steps + (hi - lo) * longint'(w.dial);
          hd = longint'(band) * steps;
          t2 = 2 * steps * t;
          if (change_age != 0 && change_age <= hold_ticks) begin
            change_age = change_age + 16'd1;
          end else begin
            if (!w.door_open && t2 > 2 * num + hd && !cooling) begin
              cooling = 1'b1;
              change_age = 16'd1;
            end
            if (t2 < 2 * num - hd && cooling) begin
              cooling = 1'b0;
              change_age = 16'd1;
            end
          end
          if (cooling) begin
            if (!w.door_open)
              fan = 1'b1;
            motor = 1'b1;
            run_heater(1'b0, 1'b0);
          end else begin
            fan = 1'b0;
            motor = 1'b0;
            run_heater(1'b1, steps * t >= num);
          end
        end
      end
      drive.fan_on = fan;
      drive.motor_on = motor;
      drive.heater_on = heater;
      drive.light_on = door_lvl;
      drive.buzzer_on = buzzer;
      expected_drive.push_back(drive);
    endfunction

    function void compare_bit(string field, logic want, logic got);
      if (got !== want) begin
        $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(ftc_out_t got);
      ftc_out_t want;
      if (expected_drive.size() == 0) begin
        $display("%0t ns: result %b arrived with nothing outstanding", $time, got);
        mismatches++;
        return;
      end
      want = expected_drive.pop_front();
      compare_bit("fan_on", want.fan_on, got.fan_on);
      compare_bit("motor_on", want.motor_on, got.motor_on);
      compare_bit("heater_on", want.heater_on, got.heater_on);
      compare_bit("light_on", want.light_on, got.light_on);
      compare_bit("buzzer_on", want.buzzer_on, got.buzzer_on);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid, in_ready, out_valid, out_ready;
  ftc_in_t in_data;
  ftc_out_t out_data;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  thermostat_tracker tracker;
  int gap_max = 19;
  int results_seen = 0;
  int stall_cycles = 0;
  int prof_lo, prof_hi, prof_band;
  logic door_now = 1'b0;
  logic [5:0] dial_now = 6'd20;

  fridge_thermostat_controller_unit #(.DIAL_STEPS(STEPS)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  // Watchdog: too long without any word moving ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int draw_gap();
    return (gap_max == 0) ? 0 : int'($urandom_range(0, gap_max));
  endfunction

  function automatic ftc_in_t make_word(logic cmd, logic door, logic [11:0] temp,
                                        logic [5:0] dial);
    ftc_in_t w;
    w.command = cmd;
    w.door_open = door;
    w.sensed_temp = temp;
    w.dial = dial;
    return w;
  endfunction

  // A temperature around the target of the current setting.
  function automatic logic [11:0] near_target(input int dial);
    int t, spread;
    t = prof_lo + ((prof_hi - prof_lo) * dial) / STEPS;
    spread = prof_band / 2 + 24;
    t = t + int'($urandom_range(0, 2 * spread)) - spread;
    if (t > 2047)
      t = 2047;
    else if (t < -2048)
      t = -2048;
    return t[11:0];
  endfunction

  // Offer one word after an optional gap and wait until it is taken.
  task automatic send_word(input ftc_in_t w, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    tracker.take_word(w);
  endtask

  task automatic write_register(input logic [2:0] index, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_register(index, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_profile(input int lo, input int hi, input int band, input int hl,
                              input int hold, input int alarm);
    write_register(REG_TARGET_MIN, lo);
    write_register(REG_TARGET_MAX, hi);
    write_register(REG_HYST_BAND, band);
    write_register(REG_HEATER_LIM, hl);
    write_register(REG_MOTOR_HOLD, hold);
    write_register(REG_DOOR_ALARM, alarm);
    prof_lo = lo;
    prof_hi = hi;
    prof_band = band;
  endtask

  // Stop offering and wait until every expected word is back.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.expected_drive.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly consistent door sequences with temperatures near target, some noise.
  task automatic run_random(input int count);
    ftc_in_t w;
    int pick;
    gap_max = 19;
    repeat (count) begin
      if ($urandom_range(0, 99) == 0)
        gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
      if ($urandom_range(0, 29) == 0)
        dial_now = ($urandom_range(0, 4) == 0) ? DIAL_OFF : 6'($urandom_range(0, STEPS - 1));
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        if ($urandom_range(0, 9) != 0)
          door_now = !door_now;
        w = make_word(CMD_DOOR, door_now, 12'($urandom), 6'($urandom));
      end else if (pick < 13) begin
        w = make_word(CMD_TICK, 1'($urandom), 12'($urandom), 6'($urandom_range(0, 63)));
      end else begin
        w = make_word(CMD_TICK, door_now, near_target(dial_now), dial_now);
      end
      send_word(w, draw_gap());
    end
  endtask

  // Result side: random stalls, with a long hold now and then to back up the block.
  initial begin : result_side
    int gap;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = (results_seen % 1000 == 500) ? PRESSURE_CYCLES : draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      tracker.check_word(out_data);
      results_seen++;
    end
  end

  initial begin : stimulus
    tracker = new();
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    settle();

    // Directed: short hold and heater pulse so each case shows in a few words.
    load_profile(64, 160, 16, 4, 2, 3);
    send_word(make_word(CMD_TICK, 1'b0, 12'sd2047, 6'd0), draw_gap());
    // Door opens while cooling: fan stops, then a tick leaves it off.
    send_word(make_word(CMD_DOOR, 1'b1, 12'sd0, 6'd0), draw_gap());
    send_word(make_word(CMD_TICK, 1'b1, 12'sd2047, 6'd0), draw_gap());
    // Door closes while the motor runs: fan comes back.
    send_word(make_word(CMD_DOOR, 1'b0, 12'sd0, 6'd0), draw_gap());
    // Cold readings: hold time first, then cooling stops and the heater pulses.
    repeat (7) send_word(make_word(CMD_TICK, 1'b0, -12'sd2048, 6'd0), draw_gap());
    // Dial at off, and beyond off.
    send_word(make_word(CMD_TICK, 1'b0, 12'sd2047, DIAL_OFF), draw_gap());
    send_word(make_word(CMD_TICK, 1'b0, 12'sd0, 6'd63), draw_gap());
    send_word(make_word(CMD_TICK, 1'b0, 12'sd2047, 6'd41), draw_gap());
    // Door left open until the buzzer sounds; a door event keeps it sounding.
    repeat (5) send_word(make_word(CMD_TICK, 1'b1, 12'sd100, 6'd20), draw_gap());
    send_word(make_word(CMD_DOOR, 1'b1, 12'sd2047, 6'd63), draw_gap());
    send_word(make_word(CMD_DOOR, 1'b0, -12'sd2048, 6'd0), draw_gap());
    send_word(make_word(CMD_TICK, 1'b0, 12'sd112, 6'd20), draw_gap());
    send_word(make_word(CMD_TICK, 1'b0, -12'sd2048, 6'd63), draw_gap());
    settle();

    // A closed-door run at full rate, then a few open ticks.
    load_profile(64, 160, 16, 80, 5, 10);
    gap_max = 0;
    send_word(make_word(CMD_DOOR, 1'b0, 12'sd0, 6'd0), 0);
    repeat (CLOSED_RUN_TICKS) begin
      dial_now = 6'($urandom_range(0, STEPS - 1));
      send_word(make_word(CMD_TICK, 1'b0, near_target(dial_now), dial_now), 0);
    end
    repeat (4) send_word(make_word(CMD_TICK, 1'b1, 12'sd100, 6'd20), 0);
    settle();

    // Random phases over several settings, the extremes among them.
    load_profile(64, 160, 16, 80, 360, 120);
    run_random(PHASE_WORDS);
    settle();
    load_profile(64, 160, 16, 80, 5, 20);
    run_random(PHASE_WORDS);
    settle();
    load_profile(-2048, 2047, 255, 0, 0, 0);
    run_random(PHASE_WORDS);
    settle();
    load_profile(2047, -2048, 0, 65534, 65533, 65535);
    run_random(PHASE_WORDS);
    settle();
    load_profile(0, 0, 1, 1, 1, 1);
    run_random(PHASE_WORDS);
    repeat (2) begin
      settle();
      load_profile(int'($urandom_range(0, 600)) - 300, int'($urandom_range(0, 600)) - 300,
                   $urandom_range(0, 64), $urandom_range(0, 40), $urandom_range(0, 12),
                   $urandom_range(0, 30));
      run_random(PHASE_WORDS);
    end
    settle();

    if (tracker.mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
